### src/mf3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median filter 3x3 package
// Shared widths, register indexes, window type and control struct.
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int PIX_W             = 8;
   localparam int CFG_W             = 12;
   localparam int CSR_IDX_W         = 2;
   localparam int WIN_SIZE          = 9;
   localparam int CENTER_IDX        = 4;
   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int HEIGHT_CAP        = 2048;
   localparam int ROW_MAX           = 4095;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd1920;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd1080;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [WIN_SIZE-1:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic emit;
      logic border;
      logic last;
   } item_ctrl_type;

endpackage

### src/mf3_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data. A read of an
// address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/mf3_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median filter 3x3 position control
// Tracks input and output raster positions and classifies each input beat:
// whether it releases an output pixel, whether that pixel is on the border and
// whether it closes the frame.
// ----------------------------------------------------------------------------
module mf3_ctrl #(
   parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [mf3_pkg::CFG_W-1:0]    image_width,
   input  logic [mf3_pkg::CFG_W-1:0]    image_height,
   output logic [$clog2(MAX_WIDTH)-1:0] column,
   output mf3_pkg::item_ctrl_type       ctrl
);
   import mf3_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW    = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

   logic [COL_W-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [CFG_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [EW-1:0]    width_ext, eff_width;
   logic [CFG_W-1:0] eff_height;
   logic             in_col_end, out_col_end, out_row_end, active, frame_end;

   always_comb begin
      width_ext = EW'(image_width);
      if (width_ext == '0) begin
         eff_width = EW'(1);
      end else if (width_ext > EW'(MAX_WIDTH)) begin
         eff_width = EW'(MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      if (image_height == '0) begin
         eff_height = CFG_W'(1);
      end else if (image_height > CFG_W'(HEIGHT_CAP)) begin
         eff_height = CFG_W'(HEIGHT_CAP);
      end else begin
         eff_height = image_height;
      end
   end

   assign in_col_end  = (EW'(in_col_ff) + EW'(1)) >= eff_width;
   assign out_col_end = (EW'(out_col_ff) + EW'(1)) >= eff_width;
   assign out_row_end = ({1'b0, out_row_ff} + (CFG_W + 1)'(1)) >= {1'b0, eff_height};
   assign active      = (in_row_ff >= CFG_W'(2)) ||
                        ((in_row_ff == CFG_W'(1)) && (in_col_ff != '0));
   assign frame_end   = out_row_end && out_col_end;

   assign column      = in_col_ff;
   assign ctrl.emit   = active;
   assign ctrl.border = (out_row_ff == '0) || out_row_end ||
                        (out_col_ff == '0) || out_col_end;
   assign ctrl.last   = frame_end;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (in_col_end) begin
         in_col_in = '0;
         if (in_row_ff != CFG_W'(ROW_MAX)) begin
            in_row_in = in_row_ff + CFG_W'(1);
         end
      end else begin
         in_col_in = in_col_ff + COL_W'(1);
      end
      if (active) begin
         if (out_col_end) begin
            out_col_in = '0;
            out_row_in = out_row_ff + CFG_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
         if (frame_end) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (advance) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

### src/mf3_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median filter 3x3 median pipeline
// Four-stage pipeline with per-stage valid: window capture, column sort,
// row selection and final median with border bypass into the output register.
// ----------------------------------------------------------------------------
module mf3_median (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  mf3_pkg::window_type          in_window,
   input  mf3_pkg::item_ctrl_type       in_ctrl,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [mf3_pkg::PIX_W-1:0]    out_pixel,
   output logic                         out_last
);
   import mf3_pkg::*;

   function automatic pixel_type min2(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pixel_type max2(input pixel_type a, input pixel_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic pixel_type med3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   logic          v0_ff, v1_ff, v2_ff, v3_ff;
   logic          free0, free1, free2, free3;
   window_type    win_ff;
   item_ctrl_type ctrl0_ff, ctrl1_ff, ctrl2_ff;
   pixel_type     [2:0] mn_in, md_in, mx_in;
   pixel_type     [2:0] mn_ff, md_ff, mx_ff;
   pixel_type     center1_ff, center2_ff;
   pixel_type     lo_ff, mi_ff, hi_ff;
   pixel_type     pixel_ff;
   logic          last_ff;

   assign free3    = !v3_ff || out_ready;
   assign free2    = !v2_ff || free3;
   assign free1    = !v1_ff || free2;
   assign free0    = !v0_ff || free1;
   assign in_ready = free0;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mn_in[c] = min2(min2(win_ff[c], win_ff[3 + c]), win_ff[6 + c]);
         mx_in[c] = max2(max2(win_ff[c], win_ff[3 + c]), win_ff[6 + c]);
         md_in[c] = med3(win_ff[c], win_ff[3 + c], win_ff[6 + c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (free0) begin
            v0_ff <= in_valid;
         end
         if (free1) begin
            v1_ff <= v0_ff;
         end
         if (free2) begin
            v2_ff <= v1_ff;
         end
         if (free3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (free0 && in_valid) begin
         win_ff   <= in_window;
         ctrl0_ff <= in_ctrl;
      end
      if (free1 && v0_ff) begin
         mn_ff      <= mn_in;
         md_ff      <= md_in;
         mx_ff      <= mx_in;
         center1_ff <= win_ff[CENTER_IDX];
         ctrl1_ff   <= ctrl0_ff;
      end
      if (free2 && v1_ff) begin
         lo_ff      <= max2(max2(mn_ff[0], mn_ff[1]), mn_ff[2]);
         mi_ff      <= med3(md_ff[0], md_ff[1], md_ff[2]);
         hi_ff      <= min2(min2(mx_ff[0], mx_ff[1]), mx_ff[2]);
         center2_ff <= center1_ff;
         ctrl2_ff   <= ctrl1_ff;
      end
      if (free3 && v2_ff) begin
         pixel_ff <= ctrl2_ff.border ? center2_ff : med3(lo_ff, mi_ff, hi_ff);
         last_ff  <= ctrl2_ff.last;
      end
   end

   assign out_valid = v3_ff;
   assign out_pixel = pixel_ff;
   assign out_last  = last_ff;

endmodule

### src/median_filter_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median filter 3x3
// Raster-order 3x3 median filter over two line stores held in one RAM.
// Path: a window completes one row plus one pixel after its centre pixel; the
//   result passes the input register and the median pipeline to the output.
// Throughput: one pixel per cycle unless the output stalls, set by one line RAM
//   read and one write-back per cycle, with forwarding when consecutive beats hit the same column.
// Reset: synchronous; clears positions, window and pipeline; the line RAM is
//   not cleared and size registers return to 1920 x 1080.
// ----------------------------------------------------------------------------
module median_filter_3x3 #(
   parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] pixel_in
   input  logic                            req_tuser,   // [0] pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] pixel_out
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mf3_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mf3_pkg::CFG_W-1:0]       csr_data
);
   import mf3_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int LINE_W = 2 * PIX_W;

   logic [CFG_W-1:0]  width_ff, height_ff;
   logic              req_accept;
   logic [COL_W-1:0]  column;
   item_ctrl_type     ctrl;

   logic              s1_valid_ff, s1_go;
   pixel_type         s1_pix_ff;
   logic [COL_W-1:0]  s1_col_ff;
   item_ctrl_type     s1_ctrl_ff;
   logic              s1_fwd_ff;
   logic [LINE_W-1:0] s1_fwd_data_ff;

   logic [LINE_W-1:0] rd_data, line_data, wr_data;
   pixel_type         line_top, line_mid;
   window_type        window_ff, window_in;
   logic              med_in_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_data;
            REG_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_accept = req_tvalid && req_tready;
   assign s1_go      = s1_valid_ff && (!s1_ctrl_ff.emit || med_in_ready);
   assign req_tready = !s1_valid_ff || s1_go;

   mf3_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .advance      (req_accept),
      .image_width  (width_ff),
      .image_height (height_ff),
      .column       (column),
      .ctrl         (ctrl)
   );

   mf3_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (req_accept),
      .rd_addr (column),
      .rd_data (rd_data)
   );

   assign line_data = s1_fwd_ff ? s1_fwd_data_ff : rd_data;
   assign line_top  = line_data[LINE_W-1:PIX_W];
   assign line_mid  = line_data[PIX_W-1:0];
   assign wr_data   = {line_mid, s1_pix_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff      <= req_tuser ? '0 : req_tdata[PIX_W-1:0];
         s1_col_ff      <= column;
         s1_ctrl_ff     <= ctrl;
         s1_fwd_ff      <= s1_go && (s1_col_ff == column);
         s1_fwd_data_ff <= wr_data;
      end
   end

   always_comb begin
      window_in = window_ff;
      for (int r = 0; r < 3; r++) begin
         window_in[r * 3]     = window_ff[r * 3 + 1];
         window_in[r * 3 + 1] = window_ff[r * 3 + 2];
      end
      window_in[2] = line_top;
      window_in[5] = line_mid;
      window_in[8] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_go) begin
         window_ff <= window_in;
      end
   end

   mf3_median u_median (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff && s1_ctrl_ff.emit),
      .in_ready  (med_in_ready),
      .in_window (window_in),
      .in_ctrl   (s1_ctrl_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

### src/mf3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median filter 3x3 port checker
// Watches the top-level ports for reset state, flow control and result count.
// ----------------------------------------------------------------------------
module mf3_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [7:0]                    rsp_tdata,
   input logic                          rsp_tlast
);

   logic        req_beat, rsp_beat;
   logic [31:0] balance_ff;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         balance_ff <= '0;
      end else begin
         balance_ff <= balance_ff + 32'(req_beat) - 32'(rsp_beat);
      end
   end

   a_reset_state: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("pipeline not empty after reset");

   a_no_input_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output is free");

   a_result_has_input: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> balance_ff != '0)
      else $error("more results than accepted beats");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

endmodule

bind median_filter_3x3 mf3_checker u_checker (.*);
